// ----- rtl/fbf_pkg.sv -----
// ----------------------------------------------------------------------------
// fbf_pkg
// Shared types and constants for the band-limiting FIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package fbf_pkg;

	localparam int SAMPLE_W           = 16;
	localparam int TAP_VALUE_W        = 16;
	localparam int TAP_INDEX_W        = 6;
	localparam int MODE_W             = 2;
	localparam int TAPS_DEFAULT       = 63;
	localparam int COEF_WIDTH_DEFAULT = 16;
	localparam int SAMPLE_MAX         = 32767;
	localparam int SAMPLE_MIN         = -32768;

	typedef enum logic [MODE_W-1:0] {
		MODE_FILTER = 2'd0,
		MODE_LOAD   = 2'd1,
		MODE_CLEAR  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT
	} state_t;

	// one tap read issued toward the MAC
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctl_t;

	// finished output sample, held until taken
	typedef struct packed {
		logic                       valid;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       clipped;
	} mac_res_t;

endpackage

`default_nettype wire

// ----- rtl/fbf_ram.sv -----
// ----------------------------------------------------------------------------
// fbf_ram
// Single-write, single-read synchronous memory with registered read.
// Per-entry valid bits make unwritten entries read as zero and allow a
// clear of the whole store.
// ----------------------------------------------------------------------------
`default_nettype none

module fbf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 63
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     clr,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (clr) begin
				vld_q <= '0;
			end
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= vld_q[raddr] ? mem_q[raddr] : '0;
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/fbf_mac.sv -----
// ----------------------------------------------------------------------------
// fbf_mac
// Shared multiply-accumulate over the tap reads, followed by round half
// away from zero and 16-bit saturation. The result holds until popped.
// ----------------------------------------------------------------------------
`default_nettype none

module fbf_mac #(
	parameter int TAPS       = fbf_pkg::TAPS_DEFAULT,
	parameter int COEF_WIDTH = fbf_pkg::COEF_WIDTH_DEFAULT
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire fbf_pkg::mac_ctl_t                    ctl,
	input  wire logic signed [COEF_WIDTH-1:0]         coef,
	input  wire logic signed [fbf_pkg::SAMPLE_W-1:0]  smp,
	input  wire logic                                 pop,
	output fbf_pkg::mac_res_t                         res
);

	import fbf_pkg::*;

	localparam int PROD_W = SAMPLE_W + COEF_WIDTH;
	localparam int ACC_W  = PROD_W + $clog2(TAPS);
	localparam int FRAC   = COEF_WIDTH - 1;
	localparam int RND_W  = ACC_W + 1;

	mac_ctl_t                  ctl_s1;
	mac_ctl_t                  ctl_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      done_s3;
	logic signed [RND_W-1:0]   bias;
	logic signed [RND_W-1:0]   rnd_q;
	logic                      res_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1    <= '0;
			ctl_s2    <= '0;
			done_s3   <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			ctl_s1  <= ctl;
			ctl_s2  <= ctl_s1;
			done_s3 <= ctl_s2.valid && ctl_s2.last;
			if (done_s3) begin
				res_vld_q <= 1'b1;
			end else if (pop) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			prod_s2 <= coef * smp;
		end
		if (ctl_s2.valid) begin
			acc_q <= (ctl_s2.first ? '0 : acc_q) + ACC_W'(prod_s2);
		end
		if (done_s3) begin
			rnd_q <= (RND_W'(acc_q) + bias) >>> FRAC;
		end
	end

	// negative sums round with half minus one, then floor
	assign bias = acc_q[ACC_W-1] ? RND_W'((1 << (FRAC - 1)) - 1) : RND_W'(1 << (FRAC - 1));

	always_comb begin
		res.valid   = res_vld_q;
		res.clipped = 1'b0;
		res.sample  = rnd_q[SAMPLE_W-1:0];
		if (rnd_q > RND_W'(SAMPLE_MAX)) begin
			res.sample  = SAMPLE_W'(SAMPLE_MAX);
			res.clipped = 1'b1;
		end else if (rnd_q < RND_W'(SAMPLE_MIN)) begin
			res.sample  = SAMPLE_W'(SAMPLE_MIN);
			res.clipped = 1'b1;
		end
	end

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s2.valid && ctl_s2.last |=> done_s3)
		else $error("sum completion not flagged");

	a_res_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_s3 |=> res_vld_q)
		else $error("result not held after completion");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && !pop |-> !done_s3)
		else $error("new sum finished over a pending result");

endmodule

`default_nettype wire

// ----- rtl/fir_bandlimit_filter.sv -----
// ----------------------------------------------------------------------------
// fir_bandlimit_filter
// Direct-form FIR low-pass over signed 16-bit samples with loadable
// Q1.15 coefficients, circular delay line and one shared MAC.
// ----------------------------------------------------------------------------
// A filter beat writes its sample at the accepting edge; then one delay-line
// and one coefficient memory read per tap feed the single multiplier, and
// the MAC pipeline registers the product, the accumulate and the rounded
// result, which is then handed off to the output register. The next beat is
// taken once the result has moved to the output register, so the input
// stalls for the whole beat, and results may wait there while the next
// sample is in work. Coefficient loads, clears and ignored beats give no
// result. Both stores reset to zero; coefficients are kept across a clear.
`default_nettype none

module fir_bandlimit_filter #(
	parameter int TAPS       = fbf_pkg::TAPS_DEFAULT,
	parameter int COEF_WIDTH = fbf_pkg::COEF_WIDTH_DEFAULT
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic [fbf_pkg::MODE_W-1:0]             mode,
	input  wire logic signed [fbf_pkg::SAMPLE_W-1:0]    sample_in,
	input  wire logic [fbf_pkg::TAP_INDEX_W-1:0]        tap_index,
	input  wire logic signed [fbf_pkg::TAP_VALUE_W-1:0] tap_value,
	input  wire logic                                   block_end,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [fbf_pkg::SAMPLE_W-1:0]         sample_out,
	output logic                                        clipped,
	output logic                                        block_end_out
);

	import fbf_pkg::*;

	localparam int IDX_W = $clog2(TAPS);
	localparam int EXT_W = COEF_WIDTH + TAP_VALUE_W;
	localparam int SHL   = (COEF_WIDTH >= TAP_VALUE_W) ? COEF_WIDTH - TAP_VALUE_W : 0;
	localparam int SHR   = (COEF_WIDTH < TAP_VALUE_W) ? TAP_VALUE_W - COEF_WIDTH : 0;

	state_t                     state_q;
	state_t                     state_d;
	logic [IDX_W-1:0]           wp_q;
	logic [IDX_W-1:0]           k_q;
	logic [IDX_W-1:0]           idx_q;
	logic                       be_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                       out_clip_q;
	logic                       out_be_q;

	logic                       accept;
	logic                       acc_filter;
	logic                       acc_load;
	logic                       acc_clear;
	logic                       k_last;
	logic                       out_load;
	logic signed [EXT_W-1:0]    tv_ext;
	logic signed [EXT_W-1:0]    tv_algn;
	logic [COEF_WIDTH-1:0]      coef_rd;
	logic [SAMPLE_W-1:0]        smp_rd;
	mac_ctl_t                   ctl;
	mac_res_t                   res;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign k_last   = (k_q == IDX_W'(TAPS - 1));

	always_comb begin
		acc_filter = 1'b0;
		acc_load   = 1'b0;
		acc_clear  = 1'b0;
		unique case (mode)
			MODE_FILTER: acc_filter = accept;
			MODE_LOAD:   acc_load   = accept && (32'(tap_index) < TAPS);
			MODE_CLEAR:  acc_clear  = accept;
			default: ;
		endcase
	end

	assign tv_ext  = EXT_W'(tap_value);
	assign tv_algn = (tv_ext <<< SHL) >>> SHR;

	assign out_load = (state_q == ST_WAIT) && res.valid && (!out_valid_q || !out_stall);

	always_comb begin
		state_d   = state_q;
		ctl.valid = 1'b0;
		ctl.first = 1'b0;
		ctl.last  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc_filter) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				ctl.valid = 1'b1;
				ctl.first = (k_q == '0);
				ctl.last  = k_last;
				if (k_last) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			k_q         <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc_clear) begin
				wp_q <= '0;
			end else if (acc_filter) begin
				wp_q  <= (wp_q == IDX_W'(TAPS - 1)) ? '0 : wp_q + 1'b1;
				idx_q <= wp_q;
				k_q   <= '0;
			end else if (state_q == ST_RUN) begin
				k_q   <= k_q + 1'b1;
				idx_q <= (idx_q == '0) ? IDX_W'(TAPS - 1) : idx_q - 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_filter) begin
			be_q <= block_end;
		end
		if (out_load) begin
			out_sample_q <= res.sample;
			out_clip_q   <= res.clipped;
			out_be_q     <= be_q;
		end
	end

	fbf_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (TAPS)
	) u_delay (
		.clk   (clk),
		.arst_n(arst_n),
		.clr   (acc_clear),
		.we    (acc_filter),
		.waddr (wp_q),
		.wdata (sample_in),
		.re    (ctl.valid),
		.raddr (idx_q),
		.rdata (smp_rd)
	);

	fbf_ram #(
		.WIDTH (COEF_WIDTH),
		.DEPTH (TAPS)
	) u_coef (
		.clk   (clk),
		.arst_n(arst_n),
		.clr   (1'b0),
		.we    (acc_load),
		.waddr (IDX_W'(tap_index)),
		.wdata (tv_algn[COEF_WIDTH-1:0]),
		.re    (ctl.valid),
		.raddr (k_q),
		.rdata (coef_rd)
	);

	fbf_mac #(
		.TAPS      (TAPS),
		.COEF_WIDTH(COEF_WIDTH)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.coef  (coef_rd),
		.smp   (smp_rd),
		.pop   (out_load),
		.res   (res)
	);

	assign out_valid     = out_valid_q;
	assign sample_out    = out_sample_q;
	assign clipped       = out_clip_q;
	assign block_end_out = out_be_q;

	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= IDX_W'(TAPS - 1))
		else $error("write position out of range");

	a_filter_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		acc_filter |=> state_q == ST_RUN && k_q == '0)
		else $error("filter beat did not start tap sweep");

	a_run_to_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN && k_last |=> state_q == ST_WAIT)
		else $error("tap sweep did not end");

	a_res_only_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> state_q == ST_WAIT)
		else $error("result pending outside wait state");

endmodule

`default_nettype wire
